### hw/rtl/wsq_pkg.sv
// shared types, defaults and result codes of the work-stealing task queues
`default_nettype none
package wsq_pkg;

    localparam int NUM_QUEUES_DEF  = 32;
    localparam int QUEUE_DEPTH_DEF = 256;
    localparam int TASK_BITS_DEF   = 64;

    localparam int QIDX_W = 5;
    localparam int WORD_W = 64;
    localparam int STAT_W = 3;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_TAKE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OWN    = 3'd0;
    localparam logic [STAT_W-1:0] ST_STOLEN = 3'd1;
    localparam logic [STAT_W-1:0] ST_NONE   = 3'd2;
    localparam logic [STAT_W-1:0] ST_PUSHED = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL   = 3'd4;

    typedef struct packed {
        logic              action;
        logic [QIDX_W-1:0] queue_index;
        logic [WORD_W-1:0] task_data;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [WORD_W-1:0] task_out;
        logic [QIDX_W-1:0] source_queue;
    } rsp_t;

endpackage
`default_nettype wire

### hw/rtl/wsq_ram.sv
// generic single-write, single-read synchronous ram with registered read
`default_nettype none
module wsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

### hw/rtl/wsq_pick.sv
// priority pick of the lowest-numbered non-empty queue other than the requester
`default_nettype none
module wsq_pick #(
    parameter int NUM_QUEUES = 32
) (
    input  wire logic [NUM_QUEUES-1:0]         nonempty,
    input  wire logic [$clog2(NUM_QUEUES)-1:0] requester,
    output logic                               found,
    output logic      [$clog2(NUM_QUEUES)-1:0] index
);

    localparam int QW = $clog2(NUM_QUEUES);

    always_comb
    begin
        found = 1'b0;
        index = '0;
        for (int i = NUM_QUEUES - 1; i >= 0; i--)
        begin
            if (nonempty[i] && (QW'(i) != requester))
            begin
                found = 1'b1;
                index = QW'(i);
            end
        end
    end

endmodule
`default_nettype wire

### hw/rtl/work_stealing_task_queues_core.sv
// top level of the work-stealing task queues: control, pointer and task memories
// A bank of ring-buffer task queues. A push transaction stores a task word at the top of
// the named queue; a take transaction pops from the top of the requester's own queue, or
// when that is empty steals the oldest task of the lowest-numbered other non-empty queue.
// Every request transaction yields exactly one response transaction. The accept cycle
// reads the queue's pointer word from the pointer memory, the next cycle writes the
// updated pointers back and accesses the task memory, and the final stage then loads
// the response into the output register once that register is free, and accepts the next
// request in the same cycle. A request can be accepted while an earlier response is
// still waiting; the block then holds the new item until the output register frees.
// No clearing pass is needed after reset.
`default_nettype none
module work_stealing_task_queues_core #(
    parameter int NUM_QUEUES  = wsq_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = wsq_pkg::QUEUE_DEPTH_DEF,
    parameter int TASK_BITS   = wsq_pkg::TASK_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire wsq_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output wsq_pkg::rsp_t      rsp
);

    import wsq_pkg::*;

    localparam int QW    = $clog2(NUM_QUEUES);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PW    = 2 * PTR_W + CNT_W;
    localparam int MEM_D = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW    = $clog2(MEM_D);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_PTR  = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    typedef enum logic [2:0] {
        OP_PUSH,
        OP_DROP,
        OP_OWN,
        OP_STEAL,
        OP_NONE
    } op_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    logic [QW-1:0]         q_reg, q_next;
    logic [QIDX_W-1:0]     src_reg, src_next;
    logic [TASK_BITS-1:0]  data_reg, data_next;
    logic [STAT_W-1:0]     stat_reg, stat_next;
    logic                  has_task_reg, has_task_next;
    logic [NUM_QUEUES-1:0] nonempty_reg, nonempty_next;
    logic [NUM_QUEUES-1:0] ptr_valid_reg, ptr_valid_next;
    logic                  ptr_rd_valid_reg, ptr_rd_valid_next;
    rsp_t                  rsp_reg, rsp_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    logic          accept;
    logic          out_free;
    logic          in_range;
    logic [QW-1:0] req_q;
    logic          own_ne;
    logic          pick_found;
    logic [QW-1:0] pick_idx;
    op_t           dec_op;
    logic [QW-1:0] dec_q;

    logic [PW-1:0]        ptr_rdata;
    logic [PW-1:0]        ptr_word;
    logic [PTR_W-1:0]     ptr_top;
    logic [PTR_W-1:0]     ptr_bot;
    logic [CNT_W-1:0]     ptr_fill;
    logic                 ptr_wr_en;
    logic [PW-1:0]        ptr_wdata;

    logic                 mem_wr_en;
    logic                 mem_rd_en;
    logic [PTR_W-1:0]     mem_ptr;
    logic [AW-1:0]        mem_addr;
    logic [TASK_BITS-1:0] mem_rdata;

    assign accept    = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !((state_reg == S_IDLE) || ((state_reg == S_FIN) && out_free));
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // request decode
    assign in_range = int'(req.queue_index) < NUM_QUEUES;
    assign req_q    = QW'(req.queue_index);
    assign own_ne   = in_range && nonempty_reg[req_q];

    wsq_pick #(
        .NUM_QUEUES(NUM_QUEUES)
    ) u_pick (
        .nonempty (nonempty_reg),
        .requester(req_q),
        .found    (pick_found),
        .index    (pick_idx)
    );

    always_comb
    begin
        if (req.action == ACT_PUSH)
        begin
            dec_op = in_range ? OP_PUSH : OP_DROP;
        end
        else if (!in_range)
        begin
            dec_op = OP_NONE;
        end
        else if (own_ne)
        begin
            dec_op = OP_OWN;
        end
        else if (pick_found)
        begin
            dec_op = OP_STEAL;
        end
        else
        begin
            dec_op = OP_NONE;
        end
        dec_q = (dec_op == OP_STEAL) ? pick_idx : req_q;
    end

    wsq_ram #(
        .WIDTH(PW),
        .DEPTH(NUM_QUEUES)
    ) u_ptr_ram (
        .clk    (clk),
        .wr_en  (ptr_wr_en),
        .wr_addr(q_reg),
        .wr_data(ptr_wdata),
        .rd_en  (accept),
        .rd_addr(dec_q),
        .rd_data(ptr_rdata)
    );

    assign ptr_word = ptr_rd_valid_reg ? ptr_rdata : '0;
    assign ptr_top  = ptr_word[PW-1 -: PTR_W];
    assign ptr_bot  = ptr_word[CNT_W +: PTR_W];
    assign ptr_fill = ptr_word[CNT_W-1:0];

    // pointer update and task memory access
    always_comb
    begin
        ptr_wr_en     = 1'b0;
        ptr_wdata     = ptr_word;
        mem_wr_en     = 1'b0;
        mem_rd_en     = 1'b0;
        mem_ptr       = ptr_top;
        stat_next     = stat_reg;
        has_task_next = has_task_reg;
        nonempty_next = nonempty_reg;
        if (state_reg == S_PTR)
        begin
            has_task_next = 1'b0;
            case (op_reg)
                OP_PUSH:
                begin
                    if (ptr_fill == CNT_FULL)
                    begin
                        stat_next = ST_FULL;
                    end
                    else
                    begin
                        stat_next            = ST_PUSHED;
                        mem_wr_en            = 1'b1;
                        ptr_wr_en            = 1'b1;
                        ptr_wdata            = {(ptr_top == PTR_LAST) ? PTR_W'(0)
                                                                      : ptr_top + PTR_W'(1),
                                                ptr_bot, ptr_fill + CNT_W'(1)};
                        nonempty_next[q_reg] = 1'b1;
                    end
                end
                OP_OWN:
                begin
                    stat_next            = ST_OWN;
                    has_task_next        = 1'b1;
                    mem_ptr              = (ptr_top == PTR_W'(0)) ? PTR_LAST
                                                                  : ptr_top - PTR_W'(1);
                    mem_rd_en            = 1'b1;
                    ptr_wr_en            = 1'b1;
                    ptr_wdata            = {mem_ptr, ptr_bot, ptr_fill - CNT_W'(1)};
                    nonempty_next[q_reg] = (ptr_fill != CNT_W'(1));
                end
                OP_STEAL:
                begin
                    stat_next            = ST_STOLEN;
                    has_task_next        = 1'b1;
                    mem_ptr              = ptr_bot;
                    mem_rd_en            = 1'b1;
                    ptr_wr_en            = 1'b1;
                    ptr_wdata            = {ptr_top,
                                            (ptr_bot == PTR_LAST) ? PTR_W'(0)
                                                                  : ptr_bot + PTR_W'(1),
                                            ptr_fill - CNT_W'(1)};
                    nonempty_next[q_reg] = (ptr_fill != CNT_W'(1));
                end
                OP_DROP:
                begin
                    stat_next = ST_FULL;
                end
                default:
                begin
                    stat_next = ST_NONE;
                end
            endcase
        end
    end

    assign mem_addr = AW'(q_reg) * AW'(QUEUE_DEPTH) + AW'(mem_ptr);

    wsq_ram #(
        .WIDTH(TASK_BITS),
        .DEPTH(MEM_D)
    ) u_task_ram (
        .clk    (clk),
        .wr_en  (mem_wr_en),
        .wr_addr(mem_addr),
        .wr_data(data_reg),
        .rd_en  (mem_rd_en),
        .rd_addr(mem_addr),
        .rd_data(mem_rdata)
    );

    // sequencing and output register
    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        q_next            = q_reg;
        src_next          = src_reg;
        data_next         = data_reg;
        ptr_rd_valid_next = ptr_rd_valid_reg;
        ptr_valid_next    = ptr_valid_reg;
        rsp_next          = rsp_reg;
        rsp_valid_next    = rsp_valid_reg && rsp_stall;

        if (ptr_wr_en)
        begin
            ptr_valid_next[q_reg] = 1'b1;
        end

        case (state_reg)
            S_PTR:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.status       = stat_reg;
                    rsp_next.task_out     = has_task_reg ? WORD_W'(mem_rdata) : '0;
                    rsp_next.source_queue = src_reg;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (accept)
        begin
            state_next        = S_PTR;
            op_next           = dec_op;
            q_next            = dec_q;
            src_next          = (dec_op == OP_STEAL) ? QIDX_W'(pick_idx) : req.queue_index;
            data_next         = TASK_BITS'(req.task_data);
            ptr_rd_valid_next = ptr_valid_reg[dec_q];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            op_reg           <= OP_NONE;
            stat_reg         <= ST_NONE;
            has_task_reg     <= 1'b0;
            nonempty_reg     <= '0;
            ptr_valid_reg    <= '0;
            ptr_rd_valid_reg <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            op_reg           <= op_next;
            stat_reg         <= stat_next;
            has_task_reg     <= has_task_next;
            nonempty_reg     <= nonempty_next;
            ptr_valid_reg    <= ptr_valid_next;
            ptr_rd_valid_reg <= ptr_rd_valid_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        src_reg  <= src_next;
        data_reg <= data_next;
        rsp_reg  <= rsp_next;
    end

    a_accept_to_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_PTR))
        else $error("accepted transaction did not reach pointer stage");

    a_own_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_PTR) && (op_reg == OP_OWN)) |-> (ptr_fill != '0))
        else $error("own pop from a queue whose fill count is zero");

    a_steal_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_PTR) && (op_reg == OP_STEAL)) |-> (ptr_fill != '0))
        else $error("steal from a queue whose fill count is zero");

    a_rsp_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("response raised outside the final stage");

endmodule
`default_nettype wire

### test/work_stealing_task_queues_checker.sv
// checker for the work-stealing task queues: shadow queues, response prediction and compare
`timescale 1ns / 100ps
module work_stealing_task_queues_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  wire logic          req_stall,
    input  wire wsq_pkg::req_t req,
    input  wire logic          rsp_valid,
    input  wire logic          rsp_stall,
    input  wire wsq_pkg::rsp_t rsp,
    output int unsigned        outstanding,
    output int unsigned        tasks_held,
    output int unsigned        steals,
    output int unsigned        drops,
    output int unsigned        errors
);

    import wsq_pkg::*;

    localparam logic [WORD_W-1:0] TASK_MASK = {WORD_W{1'b1}} >> (WORD_W - TASK_BITS_DEF);

    logic [WORD_W-1:0] shadow_task   [NUM_QUEUES_DEF][QUEUE_DEPTH_DEF];
    int unsigned       shadow_top    [NUM_QUEUES_DEF];
    int unsigned       shadow_bottom [NUM_QUEUES_DEF];
    int unsigned       shadow_fill   [NUM_QUEUES_DEF];

    rsp_t        awaited_rsp [$];
    rsp_t        oldest;
    int unsigned held_now;
    int unsigned steal_total;
    int unsigned drop_total;
    int unsigned error_total;

    function automatic rsp_t serve_request(input req_t item);
        rsp_t        outcome;
        int unsigned q;
        int unsigned slot;
        int unsigned i;
        bit          found;
        q = item.queue_index;
        outcome = '0;
        outcome.source_queue = item.queue_index;
        found = 1'b0;
        if (item.action == ACT_PUSH)
        begin
            if (q >= NUM_QUEUES_DEF || shadow_fill[q] >= QUEUE_DEPTH_DEF)
            begin
                outcome.status = ST_FULL;
                drop_total++;
            end
            else
            begin
                shadow_task[q][shadow_top[q]] = item.task_data & TASK_MASK;
                shadow_top[q] = (shadow_top[q] + 1) % QUEUE_DEPTH_DEF;
                shadow_fill[q]++;
                held_now++;
                outcome.status = ST_PUSHED;
            end
        end
        else if (q >= NUM_QUEUES_DEF)
        begin
            outcome.status = ST_NONE;
        end
        else if (shadow_fill[q] != 0)
        begin
            // own pop from the top, last in first out
            slot = (shadow_top[q] + QUEUE_DEPTH_DEF - 1) % QUEUE_DEPTH_DEF;
            shadow_top[q] = slot;
            shadow_fill[q]--;
            held_now--;
            outcome.status = ST_OWN;
            outcome.task_out = shadow_task[q][slot];
        end
        else
        begin
            // steal the oldest task of the lowest-numbered other non-empty queue
            outcome.status = ST_NONE;
            for (i = 0; i < NUM_QUEUES_DEF; i++)
            begin
                if (!found && i != q && shadow_fill[i] != 0)
                begin
                    slot = shadow_bottom[i];
                    shadow_bottom[i] = (slot + 1) % QUEUE_DEPTH_DEF;
                    shadow_fill[i]--;
                    held_now--;
                    steal_total++;
                    outcome.status = ST_STOLEN;
                    outcome.task_out = shadow_task[i][slot];
                    outcome.source_queue = i[QIDX_W-1:0];
                    found = 1'b1;
                end
            end
        end
        return outcome;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaited_rsp.delete();
            for (int k = 0; k < NUM_QUEUES_DEF; k++)
            begin
                shadow_top[k] = 0;
                shadow_bottom[k] = 0;
                shadow_fill[k] = 0;
            end
            held_now = 0;
            steal_total = 0;
            drop_total = 0;
            error_total = 0;
            outstanding <= 0;
            tasks_held <= 0;
            steals <= 0;
            drops <= 0;
            errors <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, %s %0d task %h queue %0d",
                             $time, "actual status", rsp.status, rsp.task_out,
                             rsp.source_queue);
                    error_total++;
                end
                else
                begin
                    oldest = awaited_rsp.pop_front();
                    if (rsp.status !== oldest.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, oldest.status, rsp.status);
                        error_total++;
                    end
                    if (rsp.task_out !== oldest.task_out)
                    begin
                        $display("%0t: task_out mismatch, expected %h, actual %h",
                                 $time, oldest.task_out, rsp.task_out);
                        error_total++;
                    end
                    if (rsp.source_queue !== oldest.source_queue)
                    begin
                        $display("%0t: source_queue mismatch, expected %0d, actual %0d",
                                 $time, oldest.source_queue, rsp.source_queue);
                        error_total++;
                    end
                end
            end
            if (req_valid && !req_stall)
                awaited_rsp.push_back(serve_request(req));
            outstanding <= awaited_rsp.size();
            tasks_held <= held_now;
            steals <= steal_total;
            drops <= drop_total;
            errors <= error_total;
        end
    end

endmodule

### test/work_stealing_task_queues_core_tb.sv
// testbench top for the work-stealing task queues: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module work_stealing_task_queues_core_tb;
    import wsq_pkg::*;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_stall = 1'b0;
    req_t req       = '0;
    logic req_stall;
    logic rsp_valid;
    rsp_t rsp;

    int unsigned outstanding;
    int unsigned tasks_held;
    int unsigned steals;
    int unsigned drops;
    int unsigned errors;

    int unsigned pushes_sent = 0;
    int unsigned takes_sent  = 0;
    bit          sender_quiet = 1'b0;

    always #1 clk = ~clk;

    work_stealing_task_queues_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    work_stealing_task_queues_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .outstanding (outstanding),
        .tasks_held  (tasks_held),
        .steals      (steals),
        .drops       (drops),
        .errors      (errors)
    );

    initial
    begin
        #500000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic offer(input req_t item);
        int unsigned gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do @(posedge clk); while (!(req_valid && !req_stall));
    endtask

    task automatic push_task(input int unsigned q, input logic [WORD_W-1:0] data);
        req_t item;
        item.action = ACT_PUSH;
        item.queue_index = q[QIDX_W-1:0];
        item.task_data = data;
        pushes_sent++;
        offer(item);
    endtask

    task automatic take_task(input int unsigned q);
        req_t item;
        item.action = ACT_TAKE;
        item.queue_index = q[QIDX_W-1:0];
        item.task_data = rand_word();
        takes_sent++;
        offer(item);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic drain_queues();
        wait_drained();
        while (tasks_held != 0)
            take_task($urandom_range(0, NUM_QUEUES_DEF - 1));
        wait_drained();
    endtask

    task automatic random_mix(input int unsigned count, input bit focused);
        int unsigned hot [4];
        int unsigned n;
        int unsigned q;
        for (n = 0; n < count; n++)
        begin
            if (n % 50 == 0)
                for (int k = 0; k < 4; k++)
                    hot[k] = $urandom_range(0, NUM_QUEUES_DEF - 1);
            sender_quiet = (n >= 50 && n < 110);
            if (focused && $urandom_range(0, 3) != 0)
                q = hot[$urandom_range(0, 3)];
            else
                q = $urandom_range(0, NUM_QUEUES_DEF - 1);
            if ($urandom_range(0, 99) < 55)
                push_task(q, rand_word());
            else
                take_task(q);
        end
        sender_quiet = 1'b0;
    endtask

    // response side: random stall per transaction, one long hold, one stretch with no stall
    initial
    begin : receiver
        int unsigned gap;
        int unsigned taken;
        taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken == 300)
                gap = 60;
            else if (taken >= 500 && taken < 600)
                gap = 0;
            else
                gap = $urandom_range(0, 9);
            if (gap != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!(rsp_valid && !rsp_stall));
            taken++;
        end
    end

    initial
    begin : stimulus
        int unsigned fq;
        int unsigned w;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // empty everywhere, extremes of data and index, lifo order, steals
        take_task(0);
        take_task(31);
        push_task(0, {WORD_W{1'b1}});
        push_task(31, {WORD_W{1'b0}});
        push_task(0, 64'haaaa_aaaa_aaaa_aaaa);
        take_task(0);
        take_task(5);
        take_task(0);
        take_task(31);
        push_task(17, 64'h8000_0000_0000_0001);
        push_task(17, 64'h5555_5555_5555_5555);
        push_task(3, rand_word());
        take_task(17);
        take_task(17);
        take_task(17);
        take_task(17);
        push_task(1, rand_word());
        push_task(2, rand_word());
        take_task(31);
        take_task(31);
        wait_drained();

        random_mix(150, 1'b1);
        drain_queues();

        // fill one queue past full, steal from its bottom, refill across the wrap, pop back
        fq = $urandom_range(0, NUM_QUEUES_DEF - 1);
        w = (fq + 1 + $urandom_range(0, NUM_QUEUES_DEF - 2)) % NUM_QUEUES_DEF;
        repeat (QUEUE_DEPTH_DEF + 4) push_task(fq, rand_word());
        repeat (50) take_task(w);
        repeat (60) push_task(fq, rand_word());
        repeat (30) take_task(fq);
        drain_queues();

        random_mix(50, 1'b0);
        wait_drained();
        repeat (10) @(posedge clk);

        $display("run covered %0d requests: %0d pushes and %0d takes over all queues",
                 pushes_sent + takes_sent, pushes_sent, takes_sent);
        $display("including %0d steals and %0d pushes dropped on a full queue", steals, drops);
        if (errors == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
hw/rtl/wsq_pkg.sv
hw/rtl/wsq_ram.sv
hw/rtl/wsq_pick.sv
hw/rtl/work_stealing_task_queues_core.sv
test/work_stealing_task_queues_checker.sv
test/work_stealing_task_queues_core_tb.sv
